FILE: hdl/gre_pkg.sv
// ----------------------------------------------------------------------------
// gre_pkg
// Types and constants shared by the row engine: payload structs, queue
// entry, register indexes and fixed-point formats.
// ----------------------------------------------------------------------------
package gre_pkg;

  localparam int DATA_W   = 16;
  localparam int FRAC_W   = 12;
  localparam int PROD_W   = 2 * DATA_W;
  localparam int ACC_W    = 48;
  localparam int CFG_IDX_W = 8;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BETA  = CFG_IDX_W'(1);

  localparam logic signed [DATA_W-1:0] ALPHA_RESET = DATA_W'(4096);
  localparam logic signed [DATA_W-1:0] BETA_RESET  = DATA_W'(0);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic signed [DATA_W-1:0] matrix_elem;
    logic signed [DATA_W-1:0] vector_elem;
    logic signed [DATA_W-1:0] y_prior;
    logic                     row_end;
    logic                     final_row;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] y_new;
    logic                     saturated;
    logic                     last_row;
  } out_item_t;

  typedef struct packed {
    logic signed [ACC_W-1:0]  acc;
    logic signed [DATA_W-1:0] y_prior;
    logic                     final_row;
  } row_job_t;

endpackage

FILE: hdl/gre_queue.sv
// ----------------------------------------------------------------------------
// gre_queue
// Short queue of finished row sums between the accumulate front end and
// the scaling back end.
// ----------------------------------------------------------------------------
module gre_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  gre_pkg::row_job_t            push_data,
  input  logic                         pop,
  output gre_pkg::row_job_t            pop_data,
  output logic                         empty,
  output logic [gre_pkg::QCNT_W-1:0]   count
);
  import gre_pkg::*;

  row_job_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic [QCNT_W-1:0]   count_nxt;

  assign pop_data = mem_r[rd_ptr_r];
  assign empty    = (count_r == '0);
  assign count    = count_r;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (!push && pop) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: hdl/gre_front.sv
// ----------------------------------------------------------------------------
// gre_front
// Input side: takes one element per cycle while in_stall is low, registers the
// element product and adds it into the saturating row accumulator; row ends go to the queue.
// ----------------------------------------------------------------------------
module gre_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  gre_pkg::in_item_t            in_data,
  input  logic [gre_pkg::QCNT_W-1:0]   q_count,
  output logic                         q_push,
  output gre_pkg::row_job_t            q_push_data
);
  import gre_pkg::*;

  logic                     p_valid_r;
  logic                     p_row_end_r;
  logic                     p_final_r;
  logic signed [DATA_W-1:0] p_yp_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W:0]    acc_sum;
  logic [QCNT_W:0]          occupancy;
  logic                     accept;

  assign q_push    = p_valid_r && p_row_end_r;
  // keep one free slot for the element now entering the product stage
  assign occupancy = {1'b0, q_count} + (QCNT_W+1)'(q_push);
  assign in_stall  = (occupancy >= (QCNT_W+1)'(QDEPTH));
  assign accept    = in_valid && !in_stall;

  assign acc_sum = {acc_r[ACC_W-1], acc_r} +
                   {{(ACC_W+1-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_comb begin
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_nxt = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_nxt = acc_sum[ACC_W-1:0];
    end
  end

  assign q_push_data.acc       = acc_nxt;
  assign q_push_data.y_prior   = p_yp_r;
  assign q_push_data.final_row = p_final_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      acc_r     <= '0;
    end else begin
      p_valid_r <= accept;
      if (p_valid_r) begin
        acc_r <= p_row_end_r ? '0 : acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_r      <= in_data.matrix_elem * in_data.vector_elem;
      p_row_end_r <= in_data.row_end;
      p_final_r   <= in_data.final_row;
      p_yp_r      <= in_data.y_prior;
    end
  end

endmodule

FILE: hdl/gre_scale.sv
// ----------------------------------------------------------------------------
// gre_scale
// Output side: sequencer that forms beta*y + alpha*acc for one row sum with
// split partial products, rounds, saturates and loads the output register.
// ----------------------------------------------------------------------------
module gre_scale (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic signed [gre_pkg::DATA_W-1:0] alpha_gain,
  input  logic signed [gre_pkg::DATA_W-1:0] beta_gain,
  input  logic                              q_empty,
  output logic                              q_pop,
  input  gre_pkg::row_job_t                 q_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output gre_pkg::out_item_t                out_data
);
  import gre_pkg::*;

  localparam int LO_W   = ACC_W / 2;
  localparam int HI_W   = ACC_W - LO_W;
  localparam int PLO_W  = DATA_W + LO_W + 1;
  localparam int PHI_W  = DATA_W + HI_W;
  localparam int SUM_W  = 64;
  localparam int RND_SH = 2 * FRAC_W;
  localparam int RES_W  = SUM_W - RND_SH;
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (RND_SH - 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_LO   = 5'b00010,
    ST_HI   = 5'b00100,
    ST_ADD  = 5'b01000,
    ST_SAT  = 5'b10000
  } state_t;

  state_t                   state_r;
  state_t                   state_nxt;
  row_job_t                 job_r;
  logic signed [PLO_W-1:0]  plo_r;
  logic signed [PHI_W-1:0]  phi_r;
  logic signed [PROD_W-1:0] pby_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic signed [RES_W-1:0]  res;
  logic                     res_sat;
  logic signed [DATA_W-1:0] res_clip;
  logic                     out_valid_r;
  out_item_t                out_data_r;
  logic                     out_free;
  logic                     load_out;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign load_out  = (state_r == ST_SAT) && out_free;

  assign sum_nxt = {phi_r, {LO_W{1'b0}}} +
                   {{(SUM_W-PLO_W){plo_r[PLO_W-1]}}, plo_r} +
                   {{(SUM_W-PROD_W-FRAC_W){pby_r[PROD_W-1]}}, pby_r, {FRAC_W{1'b0}}} +
                   ROUND_HALF;

  assign res     = sum_r[SUM_W-1:RND_SH];
  assign res_sat = (res[RES_W-1:DATA_W-1] != {(RES_W-DATA_W+1){1'b0}}) &&
                   (res[RES_W-1:DATA_W-1] != {(RES_W-DATA_W+1){1'b1}});
  assign res_clip = res_sat ? (res[RES_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                            : {1'b0, {(DATA_W-1){1'b1}}})
                            : res[DATA_W-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (!q_empty) state_nxt = ST_LO;
      ST_LO:   state_nxt = ST_HI;
      ST_HI:   state_nxt = ST_ADD;
      ST_ADD:  state_nxt = ST_SAT;
      ST_SAT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_data;
    end
    if (state_r == ST_LO) begin
      plo_r <= alpha_gain * $signed({1'b0, job_r.acc[LO_W-1:0]});
      pby_r <= beta_gain * job_r.y_prior;
    end
    if (state_r == ST_HI) begin
      phi_r <= alpha_gain * $signed(job_r.acc[ACC_W-1:LO_W]);
    end
    if (state_r == ST_ADD) begin
      sum_r <= sum_nxt;
    end
    if (load_out) begin
      out_data_r.y_new     <= res_clip;
      out_data_r.saturated <= res_sat;
      out_data_r.last_row  <= job_r.final_row;
    end
  end

endmodule

FILE: hdl/gemv_row_engine.sv
// ----------------------------------------------------------------------------
// gemv_row_engine
// Streaming y = beta*y + alpha*A*x in Q4.12, one matrix row at a time.
// ----------------------------------------------------------------------------
// The engine takes one matrix/vector element pair per cycle while in_stall is
// low and adds its product into a saturating 48-bit row accumulator. Each
// row end hands its sum to a four-entry queue; a scaling sequencer then takes
// each row through its steps (queue pop, two split alpha products, the wide
// add with rounding, saturation) before the result reaches the output
// register, and waits while that register is full and out_stall is high.
// The queue lets the input side keep accepting elements while the sequencer
// works on earlier rows; short rows can fill it and then stall the input.
// Configuration writes are always ready; the sequencer reads the gain
// registers directly, so a write also affects rows queued or being scaled.
// ----------------------------------------------------------------------------
module gemv_row_engine (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  gre_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output gre_pkg::out_item_t                   out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gre_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [gre_pkg::DATA_W-1:0]           cfg_data
);
  import gre_pkg::*;

  logic signed [DATA_W-1:0] alpha_r;
  logic signed [DATA_W-1:0] beta_r;
  logic                     q_push;
  logic                     q_pop;
  logic                     q_empty;
  logic [QCNT_W-1:0]        q_count;
  row_job_t                 q_push_data;
  row_job_t                 q_pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RESET;
      beta_r  <= BETA_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ALPHA: alpha_r <= cfg_data;
        REG_BETA:  beta_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  gre_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .q_count     (q_count),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  gre_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty),
    .count     (q_count)
  );

  gre_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .alpha_gain (alpha_r),
    .beta_gain  (beta_r),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_data     (q_pop_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming row engine y = beta*y + alpha*A*x.
// A scripted table runs first: values read off after reset, field extremes,
// rounding, zero alpha and ignored register indexes. Random matrices under
// several gain settings follow. Every row result is checked, against the
// table's expected value where it gives one and otherwise against a
// fixed-point row predictor, with random idling on both channels outside one calm phase.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gre_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int IDLE_PCT       = 26;
  localparam int SETTLE_CYCLES  = 16;
  localparam int TAIL_CYCLES    = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RAND_PHASES    = 8;
  localparam int PHASE_ITEMS    = 120;
  localparam int MAX_REPORTS    = 10;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = {CFG_IDX_W{1'b1}};

  typedef enum logic {STEP_ELEM, STEP_CFG} step_kind_t;

  typedef struct {
    step_kind_t            kind;
    in_item_t              item;
    bit                    typed;
    out_item_t             want;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [DATA_W-1:0]     reg_val;
  } script_step_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]  cfg_data = '0;

  // predictor state
  logic signed [DATA_W-1:0] gain_alpha = ALPHA_RESET;
  logic signed [DATA_W-1:0] gain_beta  = BETA_RESET;
  logic signed [ACC_W-1:0]  row_sum    = '0;

  out_item_t    y_expected[$];
  script_step_t script[$];

  bit calm = 1'b0;
  int mismatches = 0;
  int elems_sent = 0;
  int rows_seen  = 0;
  int cfg_writes = 0;
  int stuck_cycles = 0;

  gemv_row_engine uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic bit predict_row(input in_item_t item, output out_item_t res);
    longint a, x, yp, ga, gb, acc, total, rounded;
    longint acc_hi, acc_lo;
    bit clip;
    a = item.matrix_elem;
    x = item.vector_elem;
    yp = item.y_prior;
    ga = gain_alpha;
    gb = gain_beta;
    acc_hi = ACC_MAX;
    acc_lo = ACC_MIN;
    acc = row_sum;
    acc = acc + a * x;
    if (acc > acc_hi) acc = acc_hi;
    else if (acc < acc_lo) acc = acc_lo;
    res = '0;
    if (!item.row_end) begin
      row_sum = acc[ACC_W-1:0];
      return 1'b0;
    end
    total = ga * acc + gb * yp * (longint'(1) <<< FRAC_W);
    rounded = (total + (longint'(1) <<< (2 * FRAC_W - 1))) >>> (2 * FRAC_W);
    clip = 1'b0;
    if (rounded > 32767) begin
      rounded = 32767;
      clip = 1'b1;
    end else if (rounded < -32768) begin
      rounded = -32768;
      clip = 1'b1;
    end
    res.y_new = rounded[DATA_W-1:0];
    res.saturated = clip;
    res.last_row = item.final_row;
    row_sum = '0;
    return 1'b1;
  endfunction

  function automatic logic [DATA_W-1:0] pick_sample();
    logic [DATA_W-1:0] corner[7];
    corner = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h1000, 16'hF000};
    if ($urandom_range(0, 99) < 25) return corner[$urandom_range(0, 6)];
    return DATA_W'($urandom);
  endfunction

  function automatic void add_elem(input logic signed [DATA_W-1:0] m, v, y,
                                   input logic e, f);
    script_step_t s;
    s = '{kind: STEP_ELEM, item: '0, typed: 1'b0, want: '0, reg_idx: '0, reg_val: '0};
    s.item = '{matrix_elem: m, vector_elem: v, y_prior: y, row_end: e, final_row: f};
    script.push_back(s);
  endfunction

  function automatic void add_known(input logic signed [DATA_W-1:0] m, v, y,
                                    input logic e, f,
                                    input logic signed [DATA_W-1:0] yn,
                                    input logic sat, lr);
    add_elem(m, v, y, e, f);
    script[$].typed = 1'b1;
    script[$].want = '{y_new: yn, saturated: sat, last_row: lr};
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [DATA_W-1:0] val);
    script_step_t s;
    s = '{kind: STEP_CFG, item: '0, typed: 1'b0, want: '0, reg_idx: idx, reg_val: val};
    script.push_back(s);
  endfunction

  task automatic push_element(input in_item_t item, input bit typed, input out_item_t want);
    out_item_t res;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    elems_sent++;
    if (predict_row(item, res)) y_expected.push_back(typed ? want : res);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    in_valid <= 1'b0;
    while (y_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      REG_ALPHA: gain_alpha = val;
      REG_BETA:  gain_beta  = val;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      rows_seen++;
      if (y_expected.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected result: y_new=%0d saturated=%0b last_row=%0b",
                   out_data.y_new, out_data.saturated, out_data.last_row);
        mismatches++;
      end else begin
        want = y_expected.pop_front();
        if (out_data.y_new !== want.y_new || out_data.saturated !== want.saturated ||
            out_data.last_row !== want.last_row) begin
          if (mismatches < MAX_REPORTS)
            $display("row %0d: expected y=%0d sat=%0b last=%0b, got y=%0d sat=%0b last=%0b",
                     rows_seen, want.y_new, want.saturated, want.last_row,
                     out_data.y_new, out_data.saturated, out_data.last_row);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", stuck_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    in_item_t item;
    logic [DATA_W-1:0] ga, gb;
    int sent, row_len;

    // after reset: alpha 1.0, beta 0
    add_known(16'sd4096, 16'sd4096, 16'sd0, 1'b1, 1'b0, 16'sd4096, 1'b0, 1'b0);
    add_known(-16'sd32768, -16'sd32768, 16'sd0, 1'b1, 1'b1, 16'sd32767, 1'b1, 1'b1);
    add_known(-16'sd32768, 16'sd32767, 16'sd0, 1'b1, 1'b0, -16'sd32768, 1'b1, 1'b0);
    add_elem(16'sd4096, 16'sd4096, -16'sd1, 1'b0, 1'b1);
    add_known(16'sd4096, -16'sd4096, 16'sd0, 1'b1, 1'b0, 16'sd0, 1'b0, 1'b0);
    add_elem(16'sd2048, 16'sd4096, 16'sd0, 1'b0, 1'b0);
    add_known(16'sd2048, 16'sd4096, 16'sd7, 1'b1, 1'b1, 16'sd4096, 1'b0, 1'b1);
    // rounding half up
    add_known(16'sd1, 16'sd2048, 16'sd0, 1'b1, 1'b0, 16'sd1, 1'b0, 1'b0);
    add_known(-16'sd1, 16'sd2048, 16'sd0, 1'b1, 1'b0, 16'sd0, 1'b0, 1'b0);
    add_cfg(REG_BETA, 16'd4096);
    add_known(16'sd0, 16'sd0, 16'sd32767, 1'b1, 1'b0, 16'sd32767, 1'b0, 1'b0);
    add_known(16'sd0, 16'sd0, -16'sd32768, 1'b1, 1'b1, -16'sd32768, 1'b0, 1'b1);
    // zero alpha keeps only the beta term
    add_cfg(REG_ALPHA, 16'd0);
    add_elem(16'sd32767, 16'sd32767, 16'sd0, 1'b0, 1'b0);
    add_known(16'sd32767, 16'sd32767, 16'sd100, 1'b1, 1'b0, 16'sd100, 1'b0, 1'b0);
    add_cfg(REG_ALPHA, 16'h7FFF);
    add_cfg(REG_BETA, 16'h7FFF);
    add_known(16'sd32767, 16'sd32767, 16'sd32767, 1'b1, 1'b0, 16'sd32767, 1'b1, 1'b0);
    add_known(16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0, 16'sd0, 1'b0, 1'b0);
    add_cfg(REG_ALPHA, 16'h8000);
    add_cfg(REG_BETA, 16'h8000);
    add_known(-16'sd32768, -16'sd32768, -16'sd32768, 1'b1, 1'b1, -16'sd32768, 1'b1, 1'b1);
    add_elem(16'sd0, 16'sd0, -16'sd32768, 1'b1, 1'b0);
    // writes to unmapped indexes leave the gains alone
    add_cfg(REG_UNUSED_HI, 16'hFFFF);
    add_cfg(REG_UNUSED_LO, 16'h0000);
    add_elem(16'sd4096, 16'sd4096, 16'sd1234, 1'b1, 1'b0);
    add_elem(-16'sd1, 16'sd32767, -16'sd1, 1'b0, 1'b0);
    add_elem(16'sd12345, -16'sd321, 16'sd999, 1'b1, 1'b1);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == STEP_CFG)
        write_register(script[i].reg_idx, script[i].reg_val);
      else
        push_element(script[i].item, script[i].typed, script[i].want);
    end

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      calm = (phase == 3);
      case (phase)
        0: begin ga = 16'h1000; gb = pick_sample(); end
        1: begin ga = 16'h0000; gb = pick_sample(); end
        2: begin ga = 16'h7FFF; gb = 16'h7FFF; end
        3: begin ga = 16'h8000; gb = 16'h8000; end
        4: begin ga = pick_sample(); gb = 16'h0000; end
        default: begin ga = pick_sample(); gb = pick_sample(); end
      endcase
      write_register(REG_ALPHA, ga);
      write_register(REG_BETA, gb);
      if ($urandom_range(0, 2) == 0)
        write_register(CFG_IDX_W'($urandom_range(2, 255)), DATA_W'($urandom));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        case ($urandom_range(0, 19))
          0: row_len = $urandom_range(25, 64);
          1, 2, 3, 4, 5: row_len = $urandom_range(7, 24);
          default: row_len = $urandom_range(1, 6);
        endcase
        for (int k = 0; k < row_len; k++) begin
          item.matrix_elem = pick_sample();
          item.vector_elem = pick_sample();
          item.y_prior = pick_sample();
          item.row_end = (k == row_len - 1);
          if (item.row_end)
            item.final_row = (sent + row_len >= PHASE_ITEMS) || ($urandom_range(0, 9) == 0);
          else
            item.final_row = $urandom_range(0, 1);
          push_element(item, 1'b0, '0);
        end
        sent += row_len;
      end
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    while (y_expected.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d element transfers, %0d row results, %0d register writes",
             elems_sent, rows_seen, cfg_writes);
    $display("directed table, %0d random gain phases (one without idling), %0d mismatches",
             RAND_PHASES, mismatches);
    if (mismatches == 0 && y_expected.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
